FILE: rtl/oldest_active_lsn_tracker_macros.svh
// ----------------------------------------------------------------------------
// Oldest active LSN tracker: assertion macros
// Concurrent assertion wrappers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef OLDEST_ACTIVE_LSN_TRACKER_MACROS_SVH
`define OLDEST_ACTIVE_LSN_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define OLT_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("tracker assertion failed");
`define OLT_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tracker implication failed");
`define OLT_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tracker next-cycle check failed");
`else
`define OLT_ASSERT(name, clk, rstn, prop)
`define OLT_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define OLT_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// Shared constants and types of the oldest active LSN tracker.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int BUCKETS  = 61;
  localparam int IDX_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CNT_W    = $clog2(BUCKETS + 1);
  localparam int TXN_W    = 64;
  localparam int LSN_W    = 64;
  localparam int KIND_W   = 2;

  localparam logic [KIND_W-1:0] KIND_ENTER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEAVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic             we;
    logic             wvalid;
    logic [IDX_W-1:0] waddr;
    logic [LSN_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

endpackage

FILE: rtl/olt_hash.sv
// ----------------------------------------------------------------------------
// olt_hash
// txn_id mod BUCKETS: a weighted fold of 6-bit chunks registered at the
// start edge, then a compare-subtract ladder split over three stages.
// ----------------------------------------------------------------------------
module olt_hash import olt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TXN_W-1:0] txn_i,
  output logic             done_o,
  output logic [IDX_W-1:0] rem_o
);

  localparam int CHUNK_W = 6;
  localparam int CHUNKS  = (TXN_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W   = CHUNKS * CHUNK_W - TXN_W;
  // fold < CHUNKS * 63 * BUCKETS < BUCKETS << Q_W
  localparam int Q_W     = 10;
  localparam int S_W     = IDX_W + Q_W;

  typedef logic [CHUNKS-1:0][IDX_W-1:0] weights_t;

  // weight of chunk k: 2^(6k) mod BUCKETS
  function automatic weights_t chunk_weights();
    weights_t    w;
    int unsigned c;
    c = 1 % BUCKETS;
    for (int k = 0; k < CHUNKS; k++) begin
      w[k] = IDX_W'(c);
      c    = (c << CHUNK_W) % BUCKETS;
    end
    return w;
  endfunction

  localparam weights_t WEIGHTS = chunk_weights();

  function automatic logic [S_W-1:0] reduce_steps(input logic [S_W-1:0] x,
                                                  input int hi, input int lo);
    logic [S_W-1:0] v;
    logic [S_W-1:0] m;
    v = x;
    for (int k = Q_W - 1; k >= 0; k--) begin
      m = S_W'(BUCKETS) << k;
      if ((k <= hi) && (k >= lo) && (v >= m)) begin
        v = v - m;
      end
    end
    return v;
  endfunction

  logic [CHUNKS*CHUNK_W-1:0] txn_ext;
  logic [S_W-1:0]            fold;
  logic [3:0]                stg_q;
  logic [S_W-1:0]            s0_q;
  logic [S_W-1:0]            s1_q;
  logic [S_W-1:0]            s2_q;
  logic [IDX_W-1:0]          rem_q;

  assign txn_ext = {{PAD_W{1'b0}}, txn_i};

  always_comb begin
    fold = '0;
    for (int k = 0; k < CHUNKS; k++) begin
      fold = fold + S_W'(txn_ext[k*CHUNK_W +: CHUNK_W]) * S_W'(WEIGHTS[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else begin
      stg_q <= {stg_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s0_q <= fold;
    end
    if (stg_q[0]) begin
      s1_q <= reduce_steps(s0_q, Q_W - 1, 7);
    end
    if (stg_q[1]) begin
      s2_q <= reduce_steps(s1_q, 6, 4);
    end
    if (stg_q[2]) begin
      rem_q <= IDX_W'(reduce_steps(s2_q, 3, 0));
    end
  end

  assign done_o = stg_q[3];
  assign rem_o  = rem_q;

endmodule

FILE: rtl/olt_table.sv
// ----------------------------------------------------------------------------
// olt_table
// Low-water table: registered-read memory plus per-bucket valid bits.
// An invalid bucket reads as empty.
// ----------------------------------------------------------------------------
module olt_table import olt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_req_t         req_i,
  output logic [LSN_W-1:0] rd_data_o
);

  logic [LSN_W-1:0]   mem [BUCKETS];
  logic [BUCKETS-1:0] vld_q;
  logic [LSN_W-1:0]   rd_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= req_i.wvalid;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: rtl/oldest_active_lsn_tracker.sv
// ----------------------------------------------------------------------------
// oldest_active_lsn_tracker
// Per-bucket low-water LSN table with enter, leave and oldest-LSN scan.
//
//   channel | direction | handshake             | fields
//   in      | in        | in_valid_i/in_stall_o | kind_i, txn_id_i, lsn_i
//   out     | out       | out_valid_o/out_stall_i | status_o, oldest_lsn_o
//
// Query: result set by the scan, one table read per bucket. Enter/leave:
// the mod hash and a read-modify-write of the bucket come before the scan.
// The input stalls until the result is loaded; the next item can be taken
// in the cycle after. A result still stalled at the output holds back the
// next load.
// Reset clears the valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "oldest_active_lsn_tracker_macros.svh"

module oldest_active_lsn_tracker import olt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [TXN_W-1:0]  txn_id_i,
  input  logic [LSN_W-1:0]  lsn_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              status_o,
  output logic [LSN_W-1:0]  oldest_lsn_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_LOOKUP,
    S_UPDATE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [KIND_W-1:0] kind_q;
  logic [LSN_W-1:0]  lsn_q;
  logic [IDX_W-1:0]  slot_q;
  logic              status_q;
  logic [CNT_W-1:0]  scan_cnt_q;
  logic              cmp_vld_q;
  logic              found_q;
  logic [LSN_W-1:0]  best_q;
  logic              out_valid_q;
  logic              out_status_q;
  logic [LSN_W-1:0]  out_oldest_q;

  logic              in_acc;
  logic              needs_slot;
  logic              hash_done;
  logic [IDX_W-1:0]  hash_rem;
  logic [LSN_W-1:0]  rd_data;
  logic              occupied;
  logic              scan_issue;
  logic              out_free;
  tbl_req_t          tbl_req;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign occupied   = (rd_data != '0);
  assign scan_issue = (state_q == S_SCAN) && (scan_cnt_q < CNT_W'(BUCKETS));
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    needs_slot = 1'b0;
    case (kind_i)
      KIND_ENTER, KIND_LEAVE: needs_slot = 1'b1;
      default:                needs_slot = 1'b0;
    endcase
  end

  always_comb begin
    tbl_req        = '0;
    tbl_req.waddr  = slot_q;
    tbl_req.wdata  = lsn_q;
    tbl_req.re     = (state_q == S_LOOKUP) || scan_issue;
    tbl_req.raddr  = (state_q == S_LOOKUP) ? slot_q : scan_cnt_q[IDX_W-1:0];
    if (state_q == S_UPDATE) begin
      if (kind_q == KIND_ENTER) begin
        tbl_req.we     = !occupied;
        tbl_req.wvalid = (lsn_q != '0);
      end else if (kind_q == KIND_LEAVE) begin
        tbl_req.we     = 1'b1;
        tbl_req.wvalid = 1'b0;
      end
    end
  end

  olt_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && needs_slot),
    .txn_i   (txn_id_i),
    .done_o  (hash_done),
    .rem_o   (hash_rem)
  );

  olt_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tbl_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= KIND_QUERY;
      lsn_q        <= '0;
      slot_q       <= '0;
      status_q     <= 1'b0;
      scan_cnt_q   <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      best_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_oldest_q <= '0;
    end else begin
      cmp_vld_q <= scan_issue;
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= status_q;
        out_oldest_q <= found_q ? best_q : lsn_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmp_vld_q && occupied && (!found_q || rd_data < best_q)) begin
        best_q  <= rd_data;
        found_q <= 1'b1;
      end
      if (scan_issue) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            kind_q     <= kind_i;
            lsn_q      <= lsn_i;
            status_q   <= 1'b0;
            found_q    <= 1'b0;
            scan_cnt_q <= '0;
            state_q    <= needs_slot ? S_HASH : S_SCAN;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            slot_q  <= hash_rem;
            state_q <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          status_q <= (kind_q == KIND_ENTER) && occupied;
          state_q  <= S_SCAN;
        end
        S_SCAN: begin
          if (!scan_issue && !cmp_vld_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign oldest_lsn_o = out_oldest_q;

  `OLT_ASSERT_IMPL(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_DONE))
  `OLT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_acc, in_stall_o)
  `OLT_ASSERT_IMPL(a_write_in_update, clk_i, rst_ni, tbl_req.we, state_q == S_UPDATE)
  `OLT_ASSERT(a_scan_bound, clk_i, rst_ni, scan_cnt_q <= CNT_W'(BUCKETS))

endmodule
